@@ rtl/core/rmcv_pkg.sv @@
// Shared types and constants for the region majority class vote block.
// Holds the payload structs, operation codes, register indexes and FSM states.
// No dependencies.
package rmcv_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [8:0] region_label;
    logic [4:0] class_label;
  } in_item_t;

  typedef struct packed {
    logic [4:0] majority_class;
    logic       label_error;
    logic       count_saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CLEAR
  } state_t;

  localparam logic CFG_REGION_COUNT = 1'b0;
  localparam logic CFG_CLASS_COUNT  = 1'b1;

  localparam logic [8:0] REGION_COUNT_RST = 9'd256;
  localparam logic [4:0] CLASS_COUNT_RST  = 5'd16;

endpackage

@@ rtl/core/region_majority_class_vote.sv @@
// Region majority class vote: vote table and per-region leader in two RAMs.
// Depends on rmcv_pkg for payload structs, operation codes and states.
//
//  port group | direction | handshake         | payload
//  -----------+-----------+-------------------+---------------------------
//  in_        | input     | in_valid/in_stall | in_item_t (op, labels)
//  out_       | output    | out_valid/out_stall| out_item_t (class, flags)
//  cfg_       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each item reads the vote and leader RAMs at the accepting edge; the update
// step then writes back and loads the output register.
// A clear item answers at once and then sweeps both RAMs, one vote entry per cycle.
// The same sweep runs after reset; no item is accepted during it.
// A stalled result holds the next item in its update step until it leaves.
module region_majority_class_vote
  import rmcv_pkg::*;
#(
  parameter int MAX_REGIONS = 256,
  parameter int MAX_CLASSES = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int REG_W = $clog2(MAX_REGIONS);
  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int VT_AW = REG_W + CLS_W;
  localparam int LD_W  = COUNT_BITS + CLS_W;

  // Configuration registers.
  logic [8:0] region_count_r;
  logic [4:0] class_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= REGION_COUNT_RST;
      class_count_r  <= CLASS_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REGION_COUNT: region_count_r <= cfg_data;
        CFG_CLASS_COUNT:  class_count_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Label checks and indexes of the incoming item.
  logic             region_ok, class_ok, in_err, in_acc;
  logic [31:0]      reg_m1, cls_m1;
  logic [REG_W-1:0] in_r;
  logic [CLS_W-1:0] in_c;

  always_comb begin
    region_ok = (in_data.region_label != 9'd0)
             && (in_data.region_label <= region_count_r)
             && (32'(in_data.region_label) <= 32'(MAX_REGIONS));
    class_ok  = (in_data.class_label != 5'd0)
             && (in_data.class_label <= class_count_r)
             && (32'(in_data.class_label) <= 32'(MAX_CLASSES));
    reg_m1    = 32'(in_data.region_label) - 32'd1;
    cls_m1    = 32'(in_data.class_label) - 32'd1;
    in_r      = reg_m1[REG_W-1:0];
    in_c      = cls_m1[CLS_W-1:0];
    unique case (in_data.operation)
      OP_COUNT: in_err = !(region_ok && class_ok);
      OP_QUERY: in_err = !region_ok;
      default:  in_err = 1'b0;
    endcase
  end

  // Item in flight.
  state_t           state_r, state_nxt;
  logic [1:0]       op_r;
  logic             err_r;
  logic [REG_W-1:0] r_r;
  logic [CLS_W-1:0] c_r;
  logic [VT_AW-1:0] ctr_r, ctr_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, out_nxt;
  logic             out_load, proceed;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign proceed   = !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_data.operation;
      err_r <= in_err;
      r_r   <= in_r;
      c_r   <= in_c;
    end
  end

  // Vote table and leader RAMs, registered read.
  logic [COUNT_BITS-1:0] vt_mem [2**VT_AW];
  logic [LD_W-1:0]       ld_mem [2**REG_W];
  logic [COUNT_BITS-1:0] vt_rd_r, vt_wd;
  logic [LD_W-1:0]       ld_rd_r, ld_wd;
  logic [VT_AW-1:0]      vt_wa;
  logic [REG_W-1:0]      ld_wa;
  logic                  vt_we, ld_we;

  always_ff @(posedge clk) begin
    if (vt_we) begin
      vt_mem[vt_wa] <= vt_wd;
    end
    if (in_acc) begin
      vt_rd_r <= vt_mem[{in_r, in_c}];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      ld_mem[ld_wa] <= ld_wd;
    end
    if (in_acc) begin
      ld_rd_r <= ld_mem[in_r];
    end
  end

  // Read-modify-write arithmetic for a count.
  logic [COUNT_BITS-1:0] v_new, lead_cnt;
  logic [CLS_W-1:0]      lead_cls;
  logic [31:0]           major_w;
  logic                  v_sat, lead_wins;

  always_comb begin
    lead_cnt  = ld_rd_r[LD_W-1:CLS_W];
    lead_cls  = ld_rd_r[CLS_W-1:0];
    v_new     = (vt_rd_r == '1) ? vt_rd_r : vt_rd_r + 1'b1;
    v_sat     = (v_new == '1);
    // Higher count takes the lead; on a tie the lower class keeps or takes it.
    lead_wins = (v_new > lead_cnt) || ((v_new == lead_cnt) && (c_r < lead_cls));
    major_w   = 32'(lead_cls) + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    vt_we     = 1'b0;
    vt_wa     = {r_r, c_r};
    vt_wd     = v_new;
    ld_we     = 1'b0;
    ld_wa     = r_r;
    ld_wd     = {v_new, c_r};
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (proceed) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          out_nxt.label_error = err_r;
          if (!err_r) begin
            unique case (op_r)
              OP_COUNT: begin
                vt_we = 1'b1;
                ld_we = lead_wins;
                out_nxt.count_saturated = v_sat;
              end
              OP_QUERY: begin
                out_nxt.majority_class = major_w[4:0];
              end
              OP_CLEAR: begin
                state_nxt = ST_CLEAR;
                ctr_nxt   = '0;
              end
              default: ;
            endcase
          end
        end
      end
      ST_CLEAR: begin
        vt_we   = 1'b1;
        vt_wa   = ctr_r;
        vt_wd   = '0;
        ld_we   = 1'b1;
        ld_wa   = ctr_r[VT_AW-1:CLS_W];
        ld_wd   = '0;
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // A rejected item never touches the vote table.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && vt_we) |-> !err_r)
    else $error("vote table written for a rejected item");

  // A clear answers zeros and starts its sweep at the first entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && proceed && !err_r && op_r == OP_CLEAR)
      |=> (state_r == ST_CLEAR && ctr_r == '0 && out_valid_r && out_data_r == '0))
    else $error("clear did not answer zeros or start its sweep");

  // Only a count can report saturation, and it carries no class.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.count_saturated)
      |-> (out_data_r.majority_class == 5'd0 && !out_data_r.label_error))
    else $error("saturation flag on a result that is not a count");
`endif

endmodule
